// ===== rtl/sha512_256_hasher_macros.svh =====
// Assertion macros shared by the SHA-512/256 hasher RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SHA512_256_HASHER_MACROS_SVH
`define SHA512_256_HASHER_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define SHA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a same-cycle implication outside reset.
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication outside reset.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sha512h_pkg.sv =====
// Types, constants and round functions for the SHA-512/256 hasher.
// Depends on nothing; imported by sha512_256_hasher.
`timescale 1ns / 1ps

package sha512h_pkg;

    typedef logic [63:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    localparam int WORDS      = 16;
    localparam int CHAIN      = 8;
    localparam int ROUNDS     = 80;
    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [6:0] LAST_BYTE  = 7'd127;
    localparam logic [6:0] PRE_LEN    = 7'd111;
    localparam logic [6:0] LEN_FILL   = 7'd112;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    localparam word_t IV [CHAIN] = '{
        64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2,
        64'h2393b86b6f53b151, 64'h963877195940eabd,
        64'h96283ee2a88effe3, 64'hbe5e1e2553863992,
        64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return word_t'((x >> n) | (x << (64 - n)));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t round_k(input logic [6:0] r);
        word_t k;
        case (r)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/sha512_256_hasher.sv =====
// SHA-512/256 hasher: byte packing, padding, iterative 80-round compression.
// Depends on sha512h_pkg and sha512_256_hasher_macros.svh.
`timescale 1ns / 1ps
//
//  channel | ports                          | beat contents
//  --------+--------------------------------+-----------------------------------
//  input   | s_tvalid s_tready s_tdata      | msg_byte; tuser byte_present,
//          | s_tuser s_tlast                | tlast end_of_message
//  result  | m_tvalid m_tready m_tdata      | digest_word0..digest_word3
//
//  A data beat is packed into the current block; the beat that completes a 128-byte
//  block starts 80 rounds on one shared round unit, then one chaining add.
//  A final beat is followed by pad bytes up to byte 112 of the block, the length,
//  the compression of each block (one or two) and the load of the digest register.
//  s_tready is low during all of these steps.
//  The digest waits in its own register, so the next message is taken meanwhile;
//  a second digest holds the input until that register frees. Reset is synchronous.

`include "sha512_256_hasher_macros.svh"

module sha512_256_hasher
    import sha512h_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] msg_byte
    input  logic [0:0]   s_tuser,   // [0] byte_present
    input  logic         s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // [63:0] digest_word0, [127:64] digest_word1,
                                    // [191:128] digest_word2, [255:192] digest_word3
);

    state_t       state_reg, state_next;
    logic [6:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [55:0]  acc_reg, acc_next;
    word_t        w_reg [WORDS];
    word_t        w_next [WORDS];
    word_t        v_reg [CHAIN];
    word_t        v_next [CHAIN];
    word_t        chain_reg [CHAIN];
    word_t        chain_next [CHAIN];
    logic [6:0]   round_reg, round_next;
    logic         pad_reg, pad_next;
    logic         first_reg, first_next;
    logic         final_reg, final_next;
    logic [255:0] dig_reg, dig_next;
    logic         dig_valid_reg, dig_valid_next;

    logic        in_beat;
    logic        out_beat;
    logic        out_load;
    logic        push;
    logic [7:0]  byte_in;
    logic        word_done;
    logic        block_full;
    word_t       sched;
    word_t       t1;
    word_t       t2;

    assign in_beat    = s_tvalid && s_tready;
    assign out_beat   = m_tvalid && m_tready;
    assign out_load   = (state_reg == ST_OUT) && (!dig_valid_reg || m_tready);
    assign push       = (state_reg == ST_IDLE && in_beat && s_tuser[0]) ||
                        (state_reg == ST_PAD);
    assign byte_in    = (state_reg == ST_PAD) ? (first_reg ? PAD_BYTE : 8'h00) : s_tdata;
    assign word_done  = push && (fill_reg[2:0] == 3'b111);
    assign block_full = push && (fill_reg == LAST_BYTE);

    assign sched = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign t1    = v_reg[7] + big_sigma1(v_reg[4])
                 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                 + round_k(round_reg) + w_reg[0];
    assign t2    = big_sigma0(v_reg[0])
                 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (block_full) begin
                        state_next = ST_COMP;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (final_reg) begin
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (block_full) begin
                    state_next = ST_COMP;
                end else if (fill_reg == PRE_LEN) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                state_next = ST_COMP;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = dig_valid_reg;
        m_tdata  = dig_reg;
    end

    always_comb begin
        fill_next      = push ? 7'(fill_reg + 7'd1) : fill_reg;
        bits_next      = bits_reg;
        acc_next       = push ? {acc_reg[47:0], byte_in} : acc_reg;
        round_next     = (state_reg == ST_COMP) ? 7'(round_reg + 7'd1) : '0;
        pad_next       = pad_reg;
        first_next     = first_reg;
        final_next     = final_reg;
        w_next         = w_reg;
        chain_next     = chain_reg;
        dig_next       = dig_reg;
        dig_valid_next = dig_valid_reg && !out_beat;
        for (int i = 0; i < CHAIN; i++) begin
            v_next[i] = chain_reg[i];
        end

        if (word_done) begin
            for (int i = 0; i < WORDS - 1; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[WORDS - 1] = {acc_reg, byte_in};
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (push) begin
                    bits_next = bits_reg + BYTE_BITS;
                end
                if (in_beat && s_tlast) begin
                    pad_next   = 1'b1;
                    first_next = 1'b1;
                end
            end
            ST_COMP: begin
                for (int i = 0; i < WORDS - 1; i++) begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[WORDS - 1] = sched;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
            end
            ST_ADD: begin
                for (int i = 0; i < CHAIN; i++) begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
            end
            ST_PAD: begin
                first_next = 1'b0;
            end
            ST_LEN: begin
                for (int i = 0; i < WORDS - 2; i++) begin
                    w_next[i] = w_reg[i + 2];
                end
                w_next[WORDS - 2] = '0;
                w_next[WORDS - 1] = bits_reg;
                fill_next  = '0;
                pad_next   = 1'b0;
                final_next = 1'b1;
            end
            ST_OUT: begin
                if (out_load) begin
                    dig_next       = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
                    dig_valid_next = 1'b1;
                    chain_next     = IV;
                    fill_next      = '0;
                    bits_next      = '0;
                    final_next     = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            round_reg     <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            final_reg     <= 1'b0;
            chain_reg     <= IV;
            dig_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            round_reg     <= round_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            final_reg     <= final_next;
            chain_reg     <= chain_next;
            dig_valid_reg <= dig_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        w_reg   <= w_next;
        v_reg   <= v_next;
        dig_reg <= dig_next;
    end

    `SHA_ASSERT_NEXT(a_hold_digest, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "digest dropped while stalled")
    `SHA_ASSERT_IMPL(a_len_slot, aclk, aresetn, state_reg == ST_LEN,
        fill_reg == LEN_FILL, "length misplaced")
    `SHA_ASSERT_NEXT(a_last_round, aclk, aresetn,
        state_reg == ST_COMP && round_reg == LAST_ROUND,
        state_reg == ST_ADD, "round count overrun")
    `SHA_ASSERT_NEXT(a_restart, aclk, aresetn, out_load,
        bits_reg == '0 && fill_reg == '0 && !final_reg && m_tvalid, "state not restarted")

endmodule

// ===== dv/sha512_256_hasher_test.sv =====
// Testbench for sha512_256_hasher: random byte messages go in, 256-bit digests are checked.
// The digest tracker class predicts each digest with its own SHA-512/256 model.
// Depends on the hasher RTL only; drives both stream channels with random idling.
`timescale 1ns / 1ps

typedef bit [3:0][63:0] digest_t;

class digest_tracker;
    localparam bit [63:0] ROUND_CONST [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };
    localparam bit [63:0] START_CHAIN [8] = '{
        64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
        64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2
    };

    bit [63:0]   chain [8];
    bit [7:0]    block_bytes [128];
    int unsigned fill;
    bit [63:0]   msg_bits;
    digest_t     pending_digests [$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) chain[i] = START_CHAIN[i];
        fill = 0;
        msg_bits = '0;
    endfunction

    function bit [63:0] ror64(bit [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function void compress_block();
        bit [63:0] w [80];
        bit [63:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = '0;
            for (int j = 0; j < 8; j++) w[i] = (w[i] << 8) | 64'(block_bytes[8 * i + j]);
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
                 + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 80; i++) begin
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[i] + w[i];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // note one accepted input beat; a final beat queues the digest it causes
    function void absorb_beat(bit [7:0] data, bit present, bit last);
        digest_t dg;
        if (present) begin
            block_bytes[fill] = data;
            fill++;
            msg_bits += 64'd8;
            if (fill == 128) begin
                compress_block();
                fill = 0;
            end
        end
        if (!last) return;
        block_bytes[fill] = 8'h80;
        for (int i = fill + 1; i < 128; i++) block_bytes[i] = 8'h00;
        if (fill >= 112) begin
            compress_block();
            for (int i = 0; i < 128; i++) block_bytes[i] = 8'h00;
        end
        for (int i = 112; i < 120; i++) block_bytes[i] = 8'h00;
        for (int i = 0; i < 8; i++) block_bytes[120 + i] = msg_bits[63 - 8 * i -: 8];
        compress_block();
        for (int i = 0; i < 4; i++) dg[i] = chain[i];
        pending_digests.push_back(dg);
        restart();
    endfunction

    function void check_digest(logic [255:0] actual);
        digest_t want;
        if (pending_digests.size() == 0) begin
            $display("%0t: digest beat with none expected: expected none, got %h",
                     $time, actual);
            mismatches++;
            return;
        end
        want = pending_digests.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (actual[64 * i +: 64] !== want[i]) begin
                $display("%0t: digest_word%0d mismatch: expected %h, got %h",
                         $time, i, want[i], actual[64 * i +: 64]);
                mismatches++;
            end
        end
    endfunction

    function int unsigned pending();
        return pending_digests.size();
    endfunction
endclass

module sha512_256_hasher_test;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned PHASE_ITEMS = 567;
    localparam int unsigned HOLD_CYCLES = 500;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] msg_byte
    logic [0:0]   s_tuser  = 1'b0;    // [0] byte_present
    logic         s_tlast  = 1'b0;    // end_of_message
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;            // [63:0] digest_word0 .. [255:192] digest_word3

    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  items_sent    = 0;
    int unsigned  hold_left     = 0;
    int unsigned  cycle_count   = 0;
    bit           stall_request = 1'b0;
    digest_tracker tracker = new();

    sha512_256_hasher DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) tracker.absorb_beat(s_tdata, s_tuser[0], s_tlast);
            if (m_tvalid && m_tready) tracker.check_digest(m_tdata);
        end
    end

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // offer one beat, idling first at the sender's rate; return once it is taken
    task automatic offer_beat(input logic [7:0] data, input bit present, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the sender until every queued digest has come out
    task automatic drain_digests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_message(input int unsigned len);
        bit byte_on_final;
        byte_on_final = (len != 0) && $urandom_range(1);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
                offer_beat(8'($urandom), 1'b0, 1'b0);
                items_sent++;
            end
            offer_beat(8'($urandom), 1'b1, byte_on_final && (i == len - 1));
            items_sent++;
        end
        if (!byte_on_final) begin
            offer_beat(8'($urandom), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    function automatic int unsigned pick_length();
        int unsigned edges [11] = '{111, 112, 113, 126, 127, 128, 129, 239, 240, 255, 256};
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(16, 0);
        if (r < 82) return $urandom_range(140, 17);
        return edges[$urandom_range(10)];
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message
        offer_beat(8'h00, 1'b0, 1'b1);
        // "abc", final beat carries a byte
        offer_beat(8'h61, 1'b1, 1'b0);
        offer_beat(8'h62, 1'b1, 1'b0);
        offer_beat(8'h63, 1'b1, 1'b1);
        // byte extremes with an ignored beat inside, closed by an empty final beat
        offer_beat(8'h00, 1'b1, 1'b0);
        offer_beat(8'hff, 1'b0, 1'b0);
        offer_beat(8'hff, 1'b1, 1'b0);
        offer_beat(8'h80, 1'b1, 1'b0);
        offer_beat(8'h5a, 1'b0, 1'b1);
        // one-byte message
        offer_beat(8'hff, 1'b1, 1'b1);
        offer_beat(8'h7f, 1'b1, 1'b0);
        offer_beat(8'h01, 1'b1, 1'b0);
        offer_beat(8'hfe, 1'b1, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            drain_digests();
            case (phase)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    stall_request = 1'b1;
                end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) send_message(pick_length());
        end

        drain_digests();
        repeat (300) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
